// File: rtl/ljc_pkg.sv
// ---------------------------------------------------------------------------
// ljc_pkg: shared types, constants and arithmetic helpers
// Holds the queue entry format, state encodings and the saturating helpers
// used by the pair energy front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

package ljc_pkg;

  localparam int unsigned CoordW     = 32;
  localparam int unsigned ChargeW    = 32;
  localparam int unsigned CoefW      = 48;
  localparam int unsigned R2W        = 58;
  localparam int unsigned AccW       = 64;
  localparam int unsigned ScaleW     = 32;
  localparam int unsigned DivDendW   = 72;
  localparam int unsigned DivSorW    = 32;
  localparam int unsigned RootW      = 29;
  localparam int unsigned InDataW    = 352;
  localparam int unsigned OutDataW   = 128;
  localparam int unsigned QueueDepth = 2;

  localparam logic [ScaleW-1:0] ScaleReset = 32'd21761373;

  // What the front found out about a pair.
  typedef enum logic [1:0] {
    KIND_NORMAL,
    KIND_EXCLUDED,
    KIND_COINCIDENT
  } pair_kind_e;

  typedef struct packed {
    pair_kind_e          kind;
    logic                last;
    logic [R2W-1:0]      r2;
    logic [ChargeW-1:0]  qa;
    logic [ChargeW-1:0]  qb;
    logic [CoefW-1:0]    lj_a;
    logic [CoefW-1:0]    lj_b;
  } ljc_job_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_SQ,
    FE_PUSH
  } fe_state_e;

  typedef enum logic [4:0] {
    BK_IDLE,
    BK_NORM,
    BK_DIVQ,
    BK_MT,
    BK_MU,
    BK_MW,
    BK_MAW0,
    BK_MAW1,
    BK_MBU0,
    BK_MBU1,
    BK_F6,
    BK_VACC,
    BK_SQRT,
    BK_MQQ,
    BK_MPS0,
    BK_MPS1,
    BK_NUM,
    BK_DIVC,
    BK_EACC,
    BK_DONE
  } bk_state_e;

  // Scale x by 2^k with truncation. Bit 63 of the result is the overflow
  // flag; bits 62:0 hold the value, all ones when capped.
  function automatic logic [63:0] cap_shift(input logic [79:0] x,
                                            input logic signed [9:0] k);
    logic [142:0] xl;
    logic [79:0]  xr;
    logic [9:0]   nk;
    logic         ovf;
    logic [62:0]  v;
    ovf = 1'b0;
    v   = '0;
    xl  = '0;
    xr  = '0;
    nk  = '0;
    if (k > 10'sd0) begin
      if (x != 80'd0) begin
        if (k >= 10'sd63) begin
          ovf = 1'b1;
        end else begin
          xl  = {63'd0, x} << k[5:0];
          ovf = |xl[142:63];
          v   = xl[62:0];
        end
      end
    end else begin
      nk = 10'(-k);
      if (nk < 10'd80) begin
        xr = x >> nk[6:0];
      end
      ovf = |xr[79:63];
      v   = xr[62:0];
    end
    if (ovf) begin
      v = '1;
    end
    return {ovf, v};
  endfunction

  // Signed saturating add. Bit 64 of the result is the overflow flag.
  function automatic logic [64:0] sat_add(input logic [63:0] acc,
                                          input logic [63:0] delta);
    logic [64:0] sum;
    logic        ovf;
    logic [63:0] res;
    sum = {acc[63], acc} + {delta[63], delta};
    ovf = sum[64] != sum[63];
    res = sum[63:0];
    if (ovf) begin
      res = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return {ovf, res};
  endfunction

endpackage

`default_nettype wire

// File: rtl/ljc_front.sv
// ---------------------------------------------------------------------------
// ljc_front: pair intake and classification
// Accepts one pair, forms the squared distance one axis a cycle and queues
// the pair with its kind.
// ---------------------------------------------------------------------------
`default_nettype none

module ljc_front (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire  [ljc_pkg::InDataW-1:0]     s_axis_tdata,
  input  wire                             s_axis_tuser,
  input  wire                             s_axis_tlast,
  output logic                            push_o,
  input  wire                             full_i,
  output ljc_pkg::ljc_job_t               job_o
);

  ljc_pkg::fe_state_e state_q, state_d;
  logic [1:0]                   axis_q, axis_d;
  logic [ljc_pkg::InDataW-1:0]  data_q;
  logic                         excl_q, last_q;
  logic [63:0]                  sq_q;
  logic [ljc_pkg::R2W-1:0]      r2_q, r2_d, r2_sum;
  logic signed [32:0]           diff;
  logic [31:0]                  mag;
  logic [31:0]                  ca, cb;
  logic                         accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    case (axis_q)
      2'd0:    begin ca = data_q[31:0];  cb = data_q[127:96];  end
      2'd1:    begin ca = data_q[63:32]; cb = data_q[159:128]; end
      default: begin ca = data_q[95:64]; cb = data_q[191:160]; end
    endcase
    diff = $signed({cb[31], cb}) - $signed({ca[31], ca});
    mag  = diff[32] ? 32'(-diff) : diff[31:0];
  end

  assign r2_sum = r2_q + ljc_pkg::R2W'(sq_q[63:8]);
  assign r2_d   = (axis_q == 2'd0) ? '0 : r2_sum;

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    case (state_q)
      ljc_pkg::FE_IDLE: begin
        if (accept) begin
          state_d = ljc_pkg::FE_SQ;
          axis_d  = 2'd0;
        end
      end
      ljc_pkg::FE_SQ: begin
        if (axis_q == 2'd2) begin
          state_d = ljc_pkg::FE_PUSH;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      ljc_pkg::FE_PUSH: begin
        if (!full_i) begin
          state_d = ljc_pkg::FE_IDLE;
        end
      end
      default: state_d = ljc_pkg::FE_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    push_o        = 1'b0;
    case (state_q)
      ljc_pkg::FE_IDLE: s_axis_tready = 1'b1;
      ljc_pkg::FE_PUSH: push_o = !full_i;
      default: begin
        s_axis_tready = 1'b0;
        push_o        = 1'b0;
      end
    endcase
  end

  always_comb begin
    job_o.last = last_q;
    job_o.r2   = r2_sum;
    job_o.qa   = data_q[223:192];
    job_o.qb   = data_q[255:224];
    job_o.lj_a = data_q[303:256];
    job_o.lj_b = data_q[351:304];
    if (excl_q) begin
      job_o.kind = ljc_pkg::KIND_EXCLUDED;
    end else if (r2_sum == '0) begin
      job_o.kind = ljc_pkg::KIND_COINCIDENT;
    end else begin
      job_o.kind = ljc_pkg::KIND_NORMAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ljc_pkg::FE_IDLE;
      axis_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= s_axis_tdata;
      excl_q <= s_axis_tuser;
      last_q <= s_axis_tlast;
    end
    if (state_q == ljc_pkg::FE_SQ) begin
      sq_q <= mag * mag;
      r2_q <= r2_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ljc_fifo.sv
// ---------------------------------------------------------------------------
// ljc_fifo: pair queue
// Short register queue between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module ljc_fifo #(
  parameter int unsigned Depth = ljc_pkg::QueueDepth
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  ljc_pkg::ljc_job_t  wdata_i,
  output logic               full_o,
  input  wire                pop_i,
  output ljc_pkg::ljc_job_t  rdata_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ljc_pkg::ljc_job_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rptr_q];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= bump(wptr_q);
      if (pop_i)  rptr_q <= bump(rptr_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ljc_div.sv
// ---------------------------------------------------------------------------
// ljc_div: bit-serial unsigned divider
// Restoring division, one quotient bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ljc_div (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start_i,
  input  wire  [ljc_pkg::DivDendW-1:0]   dividend_i,
  input  wire  [ljc_pkg::DivSorW-1:0]    divisor_i,
  output logic                           busy_o,
  output logic [ljc_pkg::DivDendW-1:0]   quotient_o
);

  localparam int unsigned CntW = $clog2(ljc_pkg::DivDendW);

  logic [ljc_pkg::DivDendW-1:0] dd_q;
  logic [ljc_pkg::DivSorW-1:0]  sor_q, rem_q;
  logic [CntW-1:0]              cnt_q;
  logic                         busy_q;
  logic [ljc_pkg::DivSorW:0]    trial, diff;
  logic                         ge;

  assign trial = {rem_q, dd_q[ljc_pkg::DivDendW-1]};
  assign ge    = trial >= {1'b0, sor_q};
  assign diff  = trial - {1'b0, sor_q};

  assign busy_o     = busy_q;
  assign quotient_o = dd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(ljc_pkg::DivDendW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dd_q  <= dividend_i;
      sor_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[ljc_pkg::DivSorW-1:0] : trial[ljc_pkg::DivSorW-1:0];
      dd_q  <= {dd_q[ljc_pkg::DivDendW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: rtl/ljc_sqrt.sv
// ---------------------------------------------------------------------------
// ljc_sqrt: iterative integer square root
// Digit-by-digit root of the squared distance, one result bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ljc_sqrt (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start_i,
  input  wire  [ljc_pkg::R2W-1:0]     x_i,
  output logic                        busy_o,
  output logic [ljc_pkg::RootW-1:0]   root_o
);

  localparam int unsigned W = ljc_pkg::R2W;

  logic [W-1:0] x_q, res_q, bit_q;
  logic         busy_q;
  logic [W:0]   trial;
  logic         take;

  assign trial  = {1'b0, res_q} + {1'b0, bit_q};
  assign take   = {1'b0, x_q} >= trial;
  assign busy_o = busy_q;
  assign root_o = res_q[ljc_pkg::RootW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && bit_q[0]) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      res_q <= '0;
      bit_q <= W'(1) << (W - 2);
    end else if (busy_q) begin
      if (take) begin
        x_q   <= x_q - trial[W-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ljc_back.sv
// ---------------------------------------------------------------------------
// ljc_back: pair energy sequencer and accumulators
// Runs each normal queued pair through a shared multiplier, the divider and
// the root unit, adds both energies and presents the totals on a last pair.
// ---------------------------------------------------------------------------
`default_nettype none

module ljc_back (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire  [ljc_pkg::ScaleW-1:0]       scale_i,
  input  wire                              empty_i,
  input  ljc_pkg::ljc_job_t                job_i,
  output logic                             pop_o,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [ljc_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                             m_axis_tuser
);

  ljc_pkg::bk_state_e state_q, state_d;
  ljc_pkg::ljc_job_t  job_q;

  logic [63:0] nrm_q;
  logic [5:0]  s_q;
  logic [31:0] q_q, u_q, w_q;
  logic [63:0] p_q, prod_q;
  logic [95:0] wide_q;
  logic [62:0] f12_q, f6_q, mag_q;
  logic [ljc_pkg::RootW-1:0] root_q;
  logic [63:0] vdw_q, elec_q;
  logic        sat_q;
  logic        out_valid_q;
  logic [63:0] out_vdw_q, out_elec_q;
  logic        out_sat_q;

  logic [31:0] mul_a, mul_b;
  logic        div_start, sqrt_start;
  logic [ljc_pkg::DivDendW-1:0] div_dend;
  logic [ljc_pkg::DivSorW-1:0]  div_sor;
  logic        div_busy, sqrt_busy;
  logic [ljc_pkg::DivDendW-1:0] quo;
  logic [ljc_pkg::RootW-1:0]    root;
  logic        slot_free, normed;
  logic [31:0] mag_qa, mag_qb;
  logic        neg;
  logic [9:0]  s6, s3;
  logic signed [9:0] k12, k6;
  logic [63:0] cap12, cap6, capc;
  logic [64:0] vsum, esum;
  logic [95:0] wide_hi;

  assign slot_free = !out_valid_q || m_axis_tready;
  assign normed    = nrm_q[63];
  assign mag_qa    = job_q.qa[31] ? 32'(-job_q.qa) : job_q.qa;
  assign mag_qb    = job_q.qb[31] ? 32'(-job_q.qb) : job_q.qb;
  assign neg       = job_q.qa[31] != job_q.qb[31];
  assign s6        = 10'(s_q) * 10'd6;
  assign s3        = 10'(s_q) * 10'd3;
  assign k12       = $signed(s6 - 10'd210);
  assign k6        = $signed(s3 - 10'd117);
  assign cap12     = ljc_pkg::cap_shift(wide_q[79:0], k12);
  assign cap6      = ljc_pkg::cap_shift(wide_q[79:0], k6);
  assign capc      = ljc_pkg::cap_shift(80'(quo), 10'sd0);
  assign vsum      = ljc_pkg::sat_add(vdw_q, {1'b0, f12_q} - {1'b0, f6_q});
  assign esum      = ljc_pkg::sat_add(elec_q,
                       neg ? 64'(-{1'b0, mag_q}) : {1'b0, mag_q});
  assign wide_hi   = wide_q + {p_q, 32'd0};

  ljc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dend),
    .divisor_i  (div_sor),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  ljc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (job_q.r2),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ljc_pkg::BK_IDLE: begin
        if (!empty_i) begin
          case (job_i.kind)
            ljc_pkg::KIND_NORMAL: state_d = ljc_pkg::BK_NORM;
            default:              state_d = ljc_pkg::BK_DONE;
          endcase
        end
      end
      ljc_pkg::BK_NORM: if (normed) state_d = ljc_pkg::BK_DIVQ;
      ljc_pkg::BK_DIVQ: if (!div_busy) state_d = ljc_pkg::BK_MT;
      ljc_pkg::BK_MT:   state_d = ljc_pkg::BK_MU;
      ljc_pkg::BK_MU:   state_d = ljc_pkg::BK_MW;
      ljc_pkg::BK_MW:   state_d = ljc_pkg::BK_MAW0;
      ljc_pkg::BK_MAW0: state_d = ljc_pkg::BK_MAW1;
      ljc_pkg::BK_MAW1: state_d = ljc_pkg::BK_MBU0;
      ljc_pkg::BK_MBU0: state_d = ljc_pkg::BK_MBU1;
      ljc_pkg::BK_MBU1: state_d = ljc_pkg::BK_F6;
      ljc_pkg::BK_F6:   state_d = ljc_pkg::BK_VACC;
      ljc_pkg::BK_VACC: state_d = ljc_pkg::BK_SQRT;
      ljc_pkg::BK_SQRT: if (!sqrt_busy) state_d = ljc_pkg::BK_MQQ;
      ljc_pkg::BK_MQQ:  state_d = ljc_pkg::BK_MPS0;
      ljc_pkg::BK_MPS0: state_d = ljc_pkg::BK_MPS1;
      ljc_pkg::BK_MPS1: state_d = ljc_pkg::BK_NUM;
      ljc_pkg::BK_NUM:  state_d = ljc_pkg::BK_DIVC;
      ljc_pkg::BK_DIVC: if (!div_busy) state_d = ljc_pkg::BK_EACC;
      ljc_pkg::BK_EACC: state_d = ljc_pkg::BK_DONE;
      ljc_pkg::BK_DONE: if (!job_q.last || slot_free) state_d = ljc_pkg::BK_IDLE;
      default:          state_d = ljc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o      = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    div_dend   = {9'd0, {63{1'b1}}};
    div_sor    = nrm_q[63:32];
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      ljc_pkg::BK_IDLE: pop_o = !empty_i;
      ljc_pkg::BK_NORM: div_start = normed;
      ljc_pkg::BK_DIVQ: begin
        mul_a = quo[31:0];
        mul_b = quo[31:0];
      end
      ljc_pkg::BK_MT: begin
        mul_a = p_q[63:32];
        mul_b = q_q;
      end
      ljc_pkg::BK_MU: begin
        mul_a = p_q[63:32];
        mul_b = p_q[63:32];
      end
      ljc_pkg::BK_MW: begin
        mul_a = job_q.lj_a[31:0];
        mul_b = p_q[63:32];
      end
      ljc_pkg::BK_MAW0: begin
        mul_a = {16'd0, job_q.lj_a[47:32]};
        mul_b = w_q;
      end
      ljc_pkg::BK_MAW1: begin
        mul_a = job_q.lj_b[31:0];
        mul_b = u_q;
      end
      ljc_pkg::BK_MBU0: begin
        mul_a = {16'd0, job_q.lj_b[47:32]};
        mul_b = u_q;
      end
      ljc_pkg::BK_VACC: sqrt_start = 1'b1;
      ljc_pkg::BK_SQRT: begin
        mul_a = mag_qa;
        mul_b = mag_qb;
      end
      ljc_pkg::BK_MQQ: begin
        mul_a = p_q[31:0];
        mul_b = scale_i;
      end
      ljc_pkg::BK_MPS0: begin
        mul_a = prod_q[63:32];
        mul_b = scale_i;
      end
      ljc_pkg::BK_NUM: begin
        div_start = 1'b1;
        div_dend  = wide_q[95:24];
        div_sor   = {3'd0, root_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ljc_pkg::BK_IDLE;
      vdw_q       <= '0;
      elec_q      <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // A new result word may replace the one leaving in the same cycle.
      if (state_q == ljc_pkg::BK_DONE && job_q.last && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ljc_pkg::BK_IDLE: begin
          if (!empty_i && job_i.kind == ljc_pkg::KIND_COINCIDENT) sat_q <= 1'b1;
        end
        ljc_pkg::BK_MBU0: if (cap12[63]) sat_q <= 1'b1;
        ljc_pkg::BK_F6:   if (cap6[63]) sat_q <= 1'b1;
        ljc_pkg::BK_VACC: begin
          vdw_q <= vsum[63:0];
          if (vsum[64]) sat_q <= 1'b1;
        end
        ljc_pkg::BK_DIVC: if (!div_busy && capc[63]) sat_q <= 1'b1;
        ljc_pkg::BK_EACC: begin
          elec_q <= esum[63:0];
          if (esum[64]) sat_q <= 1'b1;
        end
        ljc_pkg::BK_DONE: begin
          if (job_q.last && slot_free) begin
            vdw_q       <= '0;
            elec_q      <= '0;
            sat_q       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    case (state_q)
      ljc_pkg::BK_IDLE: begin
        if (!empty_i) begin
          job_q <= job_i;
          nrm_q <= 64'(job_i.r2);
          s_q   <= '0;
        end
      end
      ljc_pkg::BK_NORM: begin
        if (nrm_q[63:56] == 8'd0) begin
          nrm_q <= nrm_q << 8;
          s_q   <= s_q + 6'd8;
        end else if (!normed) begin
          nrm_q <= nrm_q << 1;
          s_q   <= s_q + 6'd1;
        end
      end
      ljc_pkg::BK_DIVQ: q_q <= quo[31:0];
      ljc_pkg::BK_MU:   u_q <= p_q[63:32];
      ljc_pkg::BK_MW:   w_q <= p_q[63:32];
      ljc_pkg::BK_MAW0: wide_q <= 96'(p_q);
      ljc_pkg::BK_MAW1: wide_q <= wide_hi;
      ljc_pkg::BK_MBU0: begin
        f12_q  <= cap12[62:0];
        wide_q <= 96'(p_q);
      end
      ljc_pkg::BK_MBU1: wide_q <= wide_hi;
      ljc_pkg::BK_F6:   f6_q <= cap6[62:0];
      ljc_pkg::BK_SQRT: root_q <= root;
      ljc_pkg::BK_MQQ:  prod_q <= p_q;
      ljc_pkg::BK_MPS0: wide_q <= 96'(p_q);
      ljc_pkg::BK_MPS1: wide_q <= wide_hi;
      ljc_pkg::BK_DIVC: mag_q <= capc[62:0];
      ljc_pkg::BK_DONE: begin
        if (job_q.last && slot_free) begin
          out_vdw_q  <= vdw_q;
          out_elec_q <= elec_q;
          out_sat_q  <= sat_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_elec_q, out_vdw_q};
  assign m_axis_tuser  = out_sat_q;

endmodule

`default_nettype wire

// File: rtl/lj_coulomb_pair_energy_sum_unit.sv
// ---------------------------------------------------------------------------
// lj_coulomb_pair_energy_sum_unit: Lennard-Jones 12-6 plus Coulomb summer
// Sums pair energies over a set of atom pairs and emits both totals on the
// last pair of the set.
// ---------------------------------------------------------------------------
// The unit takes one atom pair per input word and adds its Lennard-Jones
// energy A/r^12 - B/r^6 and its Coulomb energy scale*qa*qb/r to two
// saturating Q40.24 accumulators. The word carrying tlast closes the set:
// one output word then carries both totals and a sticky saturation flag,
// and the accumulators start over from zero. An excluded pair adds nothing.
// A pair with zero squared distance that is not excluded adds nothing and
// raises the flag. Internally a front end squares the three axis differences
// in turn (tready stays low from each accepted word until the pair is
// queued) and queues the pair; a back end sequences a shared 32x32
// multiplier, a bit-serial divider and an iterative square root. A normal
// pair makes two passes through the divider and one through the root, and
// its back-end time varies with the normalizing of the squared distance.
// An excluded or coincident pair skips all three. A stalled result word
// holds the back end on the last pair of the next set.
// The coulomb scale register is written through cfg_we_i and must only
// change while the unit is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module lj_coulomb_pair_energy_sum_unit #(
  parameter int unsigned QueueDepth = ljc_pkg::QueueDepth
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [ljc_pkg::ScaleW-1:0]    cfg_wdata_i,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata from bit 0: ax, ay, az, bx, by_coord, bz, charge_a, charge_b,
  // lj_repulsive, lj_dispersive.
  input  wire  [ljc_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: excluded.
  input  wire                           s_axis_tuser,
  // tlast: last_pair.
  input  wire                           s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // tdata from bit 0: vdw_total, elec_total.
  output logic [ljc_pkg::OutDataW-1:0]  m_axis_tdata,
  // tuser: saturated.
  output logic                          m_axis_tuser
);

  // Coulomb constant, Q16.16.
  logic [ljc_pkg::ScaleW-1:0] scale_q;

  ljc_pkg::ljc_job_t push_job, head_job;
  logic push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ljc_pkg::ScaleReset;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  ljc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .push_o        (push),
    .full_i        (full),
    .job_o         (push_job)
  );

  // The queue lets the front square the next pair while the back end is
  // still busy with the previous one.
  ljc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (head_job),
    .empty_o (empty)
  );

  ljc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .scale_i       (scale_q),
    .empty_i       (empty),
    .job_i         (head_job),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// File: rtl/ljc_checker.sv
// ---------------------------------------------------------------------------
// ljc_checker: port-level checks for the pair energy summer
// Watches the stream ports of the top level over time.
// ---------------------------------------------------------------------------
`default_nettype none

module ljc_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           s_axis_tvalid,
  input wire                           s_axis_tready,
  input wire                           m_axis_tvalid,
  input wire                           m_axis_tready,
  input wire [ljc_pkg::OutDataW-1:0]   m_axis_tdata,
  input wire                           m_axis_tuser
);

  // A stalled result word keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // A stalled result word is not withdrawn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // The front squares all three axes before it takes the next pair.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
    else $error("pair taken during distance computation");

  // Leaving reset, no result is pending.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result word present after reset");

endmodule

bind lj_coulomb_pair_energy_sum_unit ljc_checker u_ljc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: verif/lj_coulomb_pair_energy_sum_unit_tb.sv
// ---------------------------------------------------------------------------
// lj_coulomb_pair_energy_sum_unit_tb: self-checking bench for the pair summer
// Streams atom pairs into the unit under random input and output idling.
// A bit-exact energy predictor computes the totals of every pair set. Each
// output word is checked against the oldest predicted totals.
// ---------------------------------------------------------------------------
`default_nettype none

module lj_coulomb_pair_energy_sum_unit_tb;

  localparam logic [63:0] PosMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NegMax = 64'h8000_0000_0000_0000;
  localparam int unsigned DrainCycles = 1000;

  // Field order from the MSB down, so that ax lands in bit 0 of tdata.
  typedef struct packed {
    logic [ljc_pkg::CoefW-1:0]   lj_b;
    logic [ljc_pkg::CoefW-1:0]   lj_a;
    logic [ljc_pkg::ChargeW-1:0] qb;
    logic [ljc_pkg::ChargeW-1:0] qa;
    logic [ljc_pkg::CoordW-1:0]  bz;
    logic [ljc_pkg::CoordW-1:0]  by_coord;
    logic [ljc_pkg::CoordW-1:0]  bx;
    logic [ljc_pkg::CoordW-1:0]  az;
    logic [ljc_pkg::CoordW-1:0]  ay;
    logic [ljc_pkg::CoordW-1:0]  ax;
  } pair_fields_t;

  typedef struct packed {
    pair_fields_t f;
    logic         excluded;
    logic         last;
  } pair_word_t;

  typedef struct packed {
    logic [63:0] vdw;
    logic [63:0] elec;
    logic        sat;
  } totals_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [ljc_pkg::ScaleW-1:0] cfg_wdata_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [ljc_pkg::OutDataW-1:0] m_axis_tdata;
  logic m_axis_tuser;

  pair_word_t pending_pairs[$];
  totals_t    expected_totals[$];
  pair_word_t pair_on_bus;
  logic       pair_held;
  int unsigned send_gap;
  int unsigned recv_gap;
  logic       idling_on;
  logic       recv_hold;
  int unsigned pairs_taken;
  int unsigned errors;

  // Predictor copy of the unit's state and register.
  logic [31:0] scale_m;
  logic [63:0] vdw_acc_m;
  logic [63:0] elec_acc_m;
  logic        sat_m;

  lj_coulomb_pair_energy_sum_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (pair_on_bus.f),
    .s_axis_tuser  (pair_on_bus.excluded),
    .s_axis_tlast  (pair_on_bus.last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Scale a wide term by 2^k with truncation, capping at the positive end.
  function automatic logic [63:0] cap_term(input logic [127:0] x, input int k);
    logic [127:0] y;
    y = '0;
    if (k <= 0) begin
      if (-k < 128) begin
        y = x >> (-k);
      end
      if (y > {64'd0, PosMax}) begin
        sat_m = 1'b1;
        return PosMax;
      end
      return y[63:0];
    end
    if (x == '0) begin
      return 64'd0;
    end
    if (k >= 63 || (x >> (63 - k)) != '0) begin
      sat_m = 1'b1;
      return PosMax;
    end
    return x[63:0] << k;
  endfunction

  function automatic logic [63:0] sat_sum(input logic [63:0] acc,
                                          input logic [63:0] delta);
    logic [64:0] sum;
    sum = {acc[63], acc} + {delta[63], delta};
    if (sum[64] != sum[63]) begin
      sat_m = 1'b1;
      return sum[64] ? NegMax : PosMax;
    end
    return sum[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] axis_square(input logic [31:0] a,
                                              input logic [31:0] b);
    logic signed [63:0] d;
    logic [63:0] mg;
    d  = 64'($signed(b)) - 64'($signed(a));
    mg = d[63] ? -d : d;
    return (mg * mg) >> 8;
  endfunction

  // Adds the Lennard-Jones and Coulomb energies of one pair to the totals.
  task automatic add_pair_energy(input pair_fields_t p);
    logic [63:0] r2, mant, q, t, u, w, f12, f6, root, qprod, mq;
    logic [63:0] mag_a, mag_b;
    logic [127:0] num;
    int s;
    r2 = axis_square(p.ax, p.bx) + axis_square(p.ay, p.by_coord)
       + axis_square(p.az, p.bz);
    if (r2 == 0) begin
      // Coincident atoms: nothing is added, but the set is flagged.
      sat_m = 1'b1;
      return;
    end
    s = 0;
    while (((r2 << s) >> 63) == 0) s++;
    mant = (r2 << s) >> 32;
    q    = PosMax / mant;
    t    = (q * q) >> 32;
    u    = (t * q) >> 32;
    w    = (u * u) >> 32;
    f12  = cap_term(128'(p.lj_a) * 128'(w), 6 * s - 210);
    f6   = cap_term(128'(p.lj_b) * 128'(u), 3 * s - 117);
    vdw_acc_m = sat_sum(vdw_acc_m, f12 - f6);

    mag_a = p.qa[31] ? -64'($signed(p.qa)) : 64'(p.qa);
    mag_b = p.qb[31] ? -64'($signed(p.qb)) : 64'(p.qb);
    qprod = mag_a * mag_b;
    root  = int_sqrt(r2);
    num   = (128'(qprod) * 128'(scale_m)) >> 24;
    mq    = cap_term(num / 128'(root), 0);
    elec_acc_m = sat_sum(elec_acc_m, (p.qa[31] != p.qb[31]) ? -mq : mq);
  endtask

  // Appends one word to the sender's queue.
  task automatic add_pending(input pair_word_t p);
    pending_pairs = {pending_pairs, p};
  endtask

  // Mostly short gaps, a few long ones, none when idling is switched off.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  // Sender: a new word goes on the bus at the falling edge once the last
  // one was taken and its gap has run out.
  always @(negedge clk_i) begin
    if (rst_ni && !pair_held) begin
      if (send_gap > 0) begin
        send_gap      <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        pair_on_bus   <= pending_pairs.pop_front();
        s_axis_tvalid <= 1'b1;
        pair_held     <= 1'b1;
        send_gap      <= pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus the long hold-off used to back up the unit.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_hold) begin
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap      <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap      <= pick_gap();
      end
    end
  end

  // Monitor: tracks register writes, predicts on each accepted pair and
  // checks each accepted result word against the oldest prediction.
  always @(posedge clk_i) begin
    totals_t got, want, pred;
    if (rst_ni) begin
      if (cfg_we_i) begin
        scale_m = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pair_held <= 1'b0;
        pairs_taken++;
        if (!pair_on_bus.excluded) begin
          add_pair_energy(pair_on_bus.f);
        end
        if (pair_on_bus.last) begin
          pred = '{vdw_acc_m, elec_acc_m, sat_m};
          expected_totals = {expected_totals, pred};
          vdw_acc_m  = '0;
          elec_acc_m = '0;
          sat_m      = 1'b0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tuser};
        if (expected_totals.size() == 0) begin
          $display("%0t: unexpected result word vdw %h elec %h sat %b", $time,
                   got.vdw, got.elec, got.sat);
          errors++;
        end else begin
          want = expected_totals.pop_front();
          if (got.vdw !== want.vdw) begin
            $display("%0t: vdw_total expected %h actual %h", $time, want.vdw, got.vdw);
            errors++;
          end
          if (got.elec !== want.elec) begin
            $display("%0t: elec_total expected %h actual %h", $time, want.elec,
                     got.elec);
            errors++;
          end
          if (got.sat !== want.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
            errors++;
          end
        end
      end
    end
  end

  function automatic pair_word_t mk_pair(input logic [31:0] ax, ay, az, bx, by_c, bz,
                                         input logic [31:0] qa, qb,
                                         input logic [47:0] lja, ljb,
                                         input logic excl, lst);
    pair_word_t p;
    p.f = '{ljb, lja, qb, qa, bz, by_c, bx, az, ay, ax};
    p.excluded = excl;
    p.last = lst;
    return p;
  endfunction

  function automatic logic [31:0] rand_charge();
    if ($urandom_range(0, 1)) begin
      return $urandom;
    end
    return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
  endfunction

  function automatic logic [47:0] rand_coef();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 12) return 48'($urandom_range(0, 32'hFFFF_FFFF)) << $urandom_range(0, 8);
    return {16'($urandom), 32'($urandom)};
  endfunction

  // One set of pairs with random content, closed by a last pair.
  task automatic queue_random_set(input int n);
    pair_word_t p;
    logic [31:0] a [3];
    logic [31:0] b [3];
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 3; k++) begin
        a[k] = $urandom;
        // Most coordinates sit within 8 angstrom of the first atom's; the rest are anywhere.
        if ($urandom_range(0, 9) < 7) begin
          b[k] = a[k] + 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
        end else begin
          b[k] = $urandom;
        end
      end
      p = mk_pair(a[0], a[1], a[2], b[0], b[1], b[2], rand_charge(), rand_charge(),
                  rand_coef(), rand_coef(), $urandom_range(0, 6) == 0, i == n - 1);
      add_pending(p);
    end
  endtask

  task automatic wait_quiet();
    while (pending_pairs.size() != 0 || pair_held || expected_totals.size() != 0)
      @(posedge clk_i);
    // A trailing excluded or in-flight pair may still be inside the unit.
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_random_phase(input int n_pairs);
    int queued;
    queued = 0;
    while (queued < n_pairs) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 12);
      idling_on = $urandom_range(0, 4) != 0;
      queue_random_set(n);
      queued += n;
      while (pending_pairs.size() > 20) @(posedge clk_i);
    end
    wait_quiet();
  endtask

  // Long receiver hold-off while the sender keeps going.
  initial begin
    recv_hold = 1'b0;
    wait (pairs_taken >= 400);
    @(negedge clk_i);
    recv_hold <= 1'b1;
    repeat (3000) @(posedge clk_i);
    @(negedge clk_i);
    recv_hold <= 1'b0;
  end

  initial begin
    #40000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    localparam logic [31:0] Ang = 32'h0010_0000;
    localparam logic [31:0] Qmax = 32'h7FFF_FFFF;
    localparam logic [31:0] Qmin = 32'h8000_0000;
    localparam logic [31:0] Qone = 32'h0100_0000;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    pair_on_bus   = '0;
    pair_held     = 1'b0;
    send_gap      = 0;
    recv_gap      = 0;
    idling_on     = 1'b1;
    pairs_taken   = 0;
    errors        = 0;
    scale_m       = ljc_pkg::ScaleReset;
    vdw_acc_m     = '0;
    elec_acc_m    = '0;
    sat_m         = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Coincident pair, then an ordinary pair: the set is flagged.
    add_pending(mk_pair(5, 6, 7, 5, 6, 7, Qone, Qone, 48'h1_0000, 48'h1_0000, 0, 0));
    add_pending(mk_pair(0, 0, 0, 3 * Ang, 0, 0, Qone, -Qone,
                        48'h0100_0000_0000, 48'h0001_0000_0000, 0, 1));
    // Excluded coincident last pair: zero totals still come out.
    add_pending(mk_pair(0, 0, 0, 0, 0, 0, Qmax, Qmax, '1, '1, 1, 1));
    // Farthest atoms possible with extreme charges and coefficients.
    add_pending(mk_pair(Qmin, Qmin, Qmin, Qmax, Qmax, Qmax, Qmin, Qmax, '1, '1, 0, 1));
    // Distance that truncates to a zero square.
    add_pending(mk_pair(0, 0, 0, 1, 1, 1, Qone, Qone, '1, 0, 0, 1));
    // Very close atoms: the repulsive term caps.
    add_pending(mk_pair(0, 0, 0, 32'd10486, 0, 0, 0, 0, '1, 0, 0, 1));
    // Repulsive caps stacking up until the accumulator saturates high.
    for (int i = 0; i < 3; i++)
      add_pending(mk_pair(0, 0, 0, 32'd20000, 0, 0, 0, 0, '1, 0, 0, i == 2));
    // Dispersive caps driving the accumulator to its low end.
    for (int i = 0; i < 2; i++)
      add_pending(mk_pair(0, 0, 0, 0, 32'd20000, 0, 0, 0, 0, '1, 0, i == 1));
    // Coulomb magnitude caps, both signs, saturating both ways.
    for (int i = 0; i < 3; i++)
      add_pending(mk_pair(0, 0, 0, 0, 0, 32'd4096, Qmin, Qmin, 0, 0, 0, i == 2));
    for (int i = 0; i < 2; i++)
      add_pending(mk_pair(0, 0, 0, 0, 0, 32'd4096, Qmin, Qmax, 0, 0, 0, i == 1));
    // Zero charges and coefficients, then an excluded middle pair.
    add_pending(mk_pair(Ang, Ang, Ang, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    add_pending(mk_pair(0, 0, 0, 2 * Ang, Ang, 0, Qone, Qone, 48'h10_0000,
                        48'h1_0000, 0, 0));
    add_pending(mk_pair(0, 0, 0, 0, 0, 0, Qone, Qone, '1, '1, 1, 0));
    add_pending(mk_pair(Qmax, 0, Qmin, Qmax - Ang, 0, Qmin + Ang, Qmin, Qmin,
                        48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 0, 1));
    wait_quiet();

    run_random_phase(230);
    write_scale('0);
    run_random_phase(230);
    write_scale('1);
    run_random_phase(230);
    write_scale($urandom);
    run_random_phase(230);
    write_scale(32'd1);
    run_random_phase(230);

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
